### hdl/ssfs_pkg.sv
// Shared types and constants for the speed source fusion selector.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package ssfs_pkg;

  localparam int SPEED_W  = 20;
  localparam int TIME_W   = 63;
  localparam int TOUT_W   = 40;
  localparam int ALPHA_W  = 9;
  localparam int CONF_W   = 8;
  localparam int SRC_W    = 3;
  localparam int IN_IDX_W = 2;
  localparam int NUM_CONF = 4;
  localparam int PROD_W   = 31;   // 21-bit signed difference times 10-bit signed alpha
  localparam int SUM_W    = 24;

  localparam int APB_AW = 6;
  localparam int APB_DW = 64;

  localparam logic [SRC_W-1:0]   NO_SOURCE = 3'd4;
  localparam logic [SPEED_W-1:0] SPEED_MAX = 20'hFFFFF;

  // Register indexes (byte address is 8 times the index)
  localparam logic [2:0] REG_CONF0   = 3'd0;
  localparam logic [2:0] REG_CONF1   = 3'd1;
  localparam logic [2:0] REG_CONF2   = 3'd2;
  localparam logic [2:0] REG_CONF3   = 3'd3;
  localparam logic [2:0] REG_TIMEOUT = 3'd4;
  localparam logic [2:0] REG_ALPHA   = 3'd5;

  localparam logic [CONF_W-1:0]  CONF0_RST   = 8'd255;
  localparam logic [CONF_W-1:0]  CONF1_RST   = 8'd192;
  localparam logic [CONF_W-1:0]  CONF2_RST   = 8'd128;
  localparam logic [CONF_W-1:0]  CONF3_RST   = 8'd64;
  localparam logic [TOUT_W-1:0]  TIMEOUT_RST = 40'd1000000000;
  localparam logic [ALPHA_W-1:0] ALPHA_RST   = 9'd64;

  typedef struct packed {
    logic [NUM_CONF-1:0][CONF_W-1:0] conf;
    logic [TOUT_W-1:0]               timeout;
    logic [ALPHA_W-1:0]              alpha;
  } cfg_t;

  typedef struct packed {
    logic start;      // item accepted: store sample, restart scan
    logic scan_step;  // evaluate one source
    logic mul;        // form blend product
    logic commit;     // update fused state and load output register
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_stall;
  } sts_t;

endpackage
`default_nettype wire

### hdl/ssfs_regs.sv
// Configuration registers behind the APB-style port.
// Depends on ssfs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ssfs_regs
  import ssfs_pkg::*;
#(
  parameter int NUM_SOURCES = 4
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg_o
);

  logic [NUM_CONF-1:0][CONF_W-1:0] conf_q;
  logic [TOUT_W-1:0]               timeout_q;
  logic [ALPHA_W-1:0]              alpha_q;
  logic [2:0]                      reg_idx;
  logic                            wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conf_q[0] <= CONF0_RST;
      conf_q[1] <= CONF1_RST;
      conf_q[2] <= CONF2_RST;
      conf_q[3] <= CONF3_RST;
      timeout_q <= TIMEOUT_RST;
      alpha_q   <= ALPHA_RST;
    end else if (wr_en) begin
      unique case (reg_idx) inside
        REG_CONF0, REG_CONF1, REG_CONF2, REG_CONF3: begin
          // sources not built keep their rank untouched
          if (32'(reg_idx) < NUM_SOURCES) begin
            conf_q[reg_idx[1:0]] <= pwdata[CONF_W-1:0];
          end
        end
        REG_TIMEOUT: timeout_q <= pwdata[TOUT_W-1:0];
        REG_ALPHA:   alpha_q   <= pwdata[ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx) inside
      REG_CONF0, REG_CONF1, REG_CONF2, REG_CONF3: prdata = APB_DW'(conf_q[reg_idx[1:0]]);
      REG_TIMEOUT: prdata = APB_DW'(timeout_q);
      REG_ALPHA:   prdata = APB_DW'(alpha_q);
      default:     prdata = '0;
    endcase
  end

  assign cfg_o.conf    = conf_q;
  assign cfg_o.timeout = timeout_q;
  assign cfg_o.alpha   = alpha_q;

endmodule
`default_nettype wire

### hdl/ssfs_ctrl.sv
// Sequencer: accept, scan the sources one a cycle, multiply, commit.
// Depends on ssfs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ssfs_ctrl
  import ssfs_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0] state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_FIN;
      end
      ST_FIN: begin
        // hold until the output register can take the result
        if (!sts_i.out_stall) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

### hdl/ssfs_dp.sv
// Datapath: per-source sample store, freshness/confidence scan, blend and
// output register. Depends on ssfs_pkg; driven by ssfs_ctrl commands.
`timescale 1ns / 1ps
`default_nettype none
module ssfs_dp
  import ssfs_pkg::*;
#(
  parameter int NUM_SOURCES = 4
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire cmd_t                cmd_i,
  output sts_t                     sts_o,
  input  wire cfg_t                cfg_i,
  input  wire logic [IN_IDX_W-1:0] source_index_i,
  input  wire logic [SPEED_W-1:0]  speed_sample_i,
  input  wire logic [TIME_W-1:0]   sample_time_ns_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic      [SPEED_W-1:0]  fused_speed_o,
  output logic      [SRC_W-1:0]    active_source_o
);

  localparam int IDX_W = $clog2(NUM_SOURCES);

  // sample store
  logic [SPEED_W-1:0]     spd_q  [NUM_SOURCES];
  logic [TIME_W-1:0]      time_q [NUM_SOURCES];
  logic [NUM_SOURCES-1:0] seen_q;
  logic [TIME_W-1:0]      now_q;

  // scan
  logic [IDX_W-1:0]   idx_q;
  logic [IDX_W+1:0]   idx_x;
  logic [IDX_W+1:0]   src_x;
  logic               src_ok;
  logic [CONF_W-1:0]  conf_sel;
  logic [TIME_W:0]    age;
  logic               fresh;
  logic               better;
  logic [CONF_W-1:0]  best_conf_q;
  logic [SRC_W-1:0]   best_src_q;
  logic [SPEED_W-1:0] best_val_q;

  // blend
  logic signed [SPEED_W:0]   diff;
  logic signed [ALPHA_W:0]   alpha_s;
  logic signed [PROD_W-1:0]  prod_d, prod_q;
  logic signed [PROD_W-1:0]  step;
  logic signed [SUM_W-1:0]   sum;
  logic [SPEED_W-1:0]        blended;
  logic                      need_blend;
  logic [SPEED_W-1:0]        fused_d;

  logic [SPEED_W-1:0] cur_speed_q;
  logic [SRC_W-1:0]   cur_src_q;
  logic               out_valid_q;
  logic [SPEED_W-1:0] out_speed_q;
  logic [SRC_W-1:0]   out_src_q;

  assign src_x  = (IDX_W+2)'(source_index_i);
  assign src_ok = 32'(source_index_i) < NUM_SOURCES;
  assign idx_x  = (IDX_W+2)'(idx_q);

  // sources without a rank register never win
  assign conf_sel = (idx_x < (IDX_W+2)'(NUM_CONF)) ? cfg_i.conf[idx_x[1:0]] : '0;

  // negative age (stored time in the future) shows as a borrow
  assign age    = {1'b0, now_q} - {1'b0, time_q[idx_q]};
  assign fresh  = seen_q[idx_q] && !age[TIME_W] &&
                  (age[TIME_W-1:0] <= TIME_W'(cfg_i.timeout));
  assign better = fresh && (conf_sel > best_conf_q);

  assign sts_o.scan_last = (32'(idx_q) == NUM_SOURCES - 1);
  assign sts_o.out_stall = out_valid_q && !out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
      idx_q  <= '0;
    end else if (cmd_i.start) begin
      idx_q <= '0;
      if (src_ok) begin
        seen_q[src_x[IDX_W-1:0]] <= 1'b1;
      end
    end else if (cmd_i.scan_step && !sts_o.scan_last) begin
      idx_q <= idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      now_q       <= sample_time_ns_i;
      best_conf_q <= '0;
      best_src_q  <= NO_SOURCE;
      if (src_ok) begin
        spd_q[src_x[IDX_W-1:0]]  <= speed_sample_i;
        time_q[src_x[IDX_W-1:0]] <= sample_time_ns_i;
      end
    end else if (cmd_i.scan_step && better) begin
      best_conf_q <= conf_sel;
      best_src_q  <= SRC_W'(idx_q);
      best_val_q  <= spd_q[idx_q];
    end
  end

  // blend: old + floor((new - old) * alpha / 256), saturated
  assign diff    = $signed({1'b0, best_val_q}) - $signed({1'b0, cur_speed_q});
  assign alpha_s = $signed({1'b0, cfg_i.alpha});
  assign prod_d  = diff * alpha_s;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= prod_d;
    end
  end

  assign step = prod_q >>> 8;
  assign sum  = $signed({{(SUM_W-SPEED_W){1'b0}}, cur_speed_q}) + step[SUM_W-1:0];

  always_comb begin
    if (sum < 0) begin
      blended = '0;
    end else if (sum > $signed(SUM_W'(SPEED_MAX))) begin
      blended = SPEED_MAX;
    end else begin
      blended = sum[SPEED_W-1:0];
    end
  end

  assign need_blend = (best_src_q != NO_SOURCE) && (cur_src_q != NO_SOURCE) &&
                      (best_src_q != cur_src_q);

  always_comb begin
    if (best_src_q == NO_SOURCE) begin
      fused_d = cur_speed_q;
    end else if (need_blend) begin
      fused_d = blended;
    end else begin
      fused_d = best_val_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_speed_q <= '0;
      cur_src_q   <= NO_SOURCE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        cur_speed_q <= fused_d;
        cur_src_q   <= best_src_q;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_speed_q <= fused_d;
      out_src_q   <= best_src_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign fused_speed_o   = out_speed_q;
  assign active_source_o = out_src_q;

  a_commit_not_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> !(out_valid_q && !out_ready_i))
    else $error("result committed over an item still waiting");

  a_hold_when_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && best_src_q == NO_SOURCE) |=> cur_speed_q == $past(cur_speed_q))
    else $error("fused speed moved with no fresh source");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(idx_q) < NUM_SOURCES)
    else $error("scan index past last source");

  a_source_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (active_source_o == NO_SOURCE || 32'(active_source_o) < NUM_SOURCES))
    else $error("active source code out of range");

endmodule
`default_nettype wire

### hdl/speed_source_fusion_selector.sv
// Top level of the speed source fusion selector: registers, sequencer and
// datapath. Depends on ssfs_pkg, ssfs_regs, ssfs_ctrl and ssfs_dp.
//
//  channel | handshake              | payload
//  --------+------------------------+------------------------------------------
//  in      | in_valid_i / in_ready_o| source_index_i, speed_sample_i, sample_time_ns_i
//  out     | out_valid_o/out_ready_i| fused_speed_o, active_source_o
//  cfg     | psel, penable, pwrite  | paddr, pwdata, prdata (pready tied high)
//
// An item is stored, then the freshness/rank scan visits every source in turn,
// then the blend multiply runs and the result commits; the next item is
// accepted only after the commit, which can stall on a full output register.
// Reset clears seen flags, fused speed (to 0) and source (to none); no sweep.
// A new item is accepted while the previous result waits; commit holds while
// the output register is full and not taken.
`timescale 1ns / 1ps
`default_nettype none
module speed_source_fusion_selector
  import ssfs_pkg::*;
#(
  parameter int NUM_SOURCES = 4
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [IN_IDX_W-1:0] source_index_i,
  input  wire logic [SPEED_W-1:0]  speed_sample_i,
  input  wire logic [TIME_W-1:0]   sample_time_ns_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic      [SPEED_W-1:0]  fused_speed_o,
  output logic      [SRC_W-1:0]    active_source_o,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [APB_AW-1:0]   paddr,
  input  wire logic [APB_DW-1:0]   pwdata,
  output logic      [APB_DW-1:0]   prdata,
  output logic                     pready
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  ssfs_regs #(
    .NUM_SOURCES (NUM_SOURCES)
  ) u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ssfs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ssfs_dp #(
    .NUM_SOURCES (NUM_SOURCES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_i            (cfg),
    .source_index_i   (source_index_i),
    .speed_sample_i   (speed_sample_i),
    .sample_time_ns_i (sample_time_ns_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .fused_speed_o    (fused_speed_o),
    .active_source_o  (active_source_o)
  );

endmodule
`default_nettype wire
